// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert a property on the rising clock edge, off during reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// assert that one condition implies another in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, cond, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

// ===== rtl/sbrt_pkg.sv =====
// ----------------------------------------------------------------------------
// sbrt_pkg
// Types and constants of the servo bus register transaction unit.
// ----------------------------------------------------------------------------
package sbrt_pkg;

   localparam logic [2:0] CMD_READ       = 3'd0;
   localparam logic [2:0] CMD_WRITE_BYTE = 3'd1;
   localparam logic [2:0] CMD_WRITE_WORD = 3'd2;
   localparam logic [2:0] CMD_RX_BYTE    = 3'd3;
   localparam logic [2:0] CMD_TICK       = 3'd4;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
   localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

   localparam logic       KIND_BYTE    = 1'b0;
   localparam logic       KIND_OUTCOME = 1'b1;

   localparam logic [7:0]  SYNC_BYTE      = 8'hFF;
   localparam logic [7:0]  CHECKSUM_GOOD  = 8'hFF;
   localparam logic [7:0]  INSTR_READ     = 8'd2;
   localparam logic [7:0]  INSTR_WRITE    = 8'd3;
   localparam logic [7:0]  LEN_SHORT      = 8'd4;
   localparam logic [7:0]  LEN_WORD       = 8'd5;
   localparam logic [8:0]  STATUS_EXTRA   = 9'd6;
   localparam logic [8:0]  TOTAL_MAX      = 9'd255;
   localparam logic [15:0] TIMEOUT_RESET  = 16'd3000;
   localparam logic [3:0]  PKT_LEN_SHORT  = 4'd8;
   localparam logic [3:0]  PKT_LEN_WORD   = 4'd9;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_HUNT    = 2'd1,
      PH_COLLECT = 2'd2
   } phase_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  servo_id;
      logic [7:0]  reg_addr;
      logic [7:0]  read_len;
      logic [15:0] write_data;
      logic [7:0]  rx_byte;
   } sbrt_req_type;

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  tx_byte;
      logic        last;
      logic [1:0]  status;
      logic [15:0] read_value;
      logic [7:0]  servo_error;
   } sbrt_rsp_type;

   typedef struct packed {
      logic [8:0][7:0] bytes;
      logic [3:0]      len;
   } sbrt_pkt_type;

endpackage

// ===== rtl/servo_bus_register_transaction_unit.sv =====
// ----------------------------------------------------------------------------
// servo_bus_register_transaction_unit
// Master side of a half-duplex servo register bus. Requests are turned into
// instruction packets sent out one byte beat per cycle on the rsp channel
// while rsp_ready is high; a read then hunts for a status packet among the
// received bytes, checks its checksum and reports one outcome beat (ok,
// timeout or checksum mismatch). Received bytes, ticks and ignored commands
// may follow back to back while req_ready is high. A request occupies the
// single result register for its 8 or 9 byte beats: req_ready drops while the
// packet drains and rises again with its last beat. The timeout register is
// loaded into the tick counter at each read request and each received byte
// in the hunt or collect phase.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module servo_bus_register_transaction_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sbrt_pkg::sbrt_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sbrt_pkg::sbrt_rsp_type rsp_data,
   input  logic                   csr_wr_en,
   input  logic [15:0]            csr_wr_data
);
   import sbrt_pkg::*;

   logic            req_fire;
   logic            rsp_fire;
   sbrt_pkt_type    pkt;

   logic [15:0]     timeout_ff;
   phase_type       phase_ff, phase_in;
   logic [7:0]      pos_ff, pos_in;
   logic [7:0]      total_ff, total_in;
   logic [7:0]      sum_ff, sum_in;
   logic [15:0]     ticks_ff, ticks_in;
   logic [7:0]      count_ff, count_in;
   logic [7:0]      err_ff, err_in;
   logic [7:0]      vlo_ff, vlo_in;
   logic [7:0]      vhi_ff, vhi_in;

   logic [8:0][7:0] bytes_ff, bytes_in;
   logic [3:0]      cnt_ff, cnt_in;
   logic            kind_ff, kind_in;
   logic [1:0]      status_ff, status_in;
   logic [15:0]     value_ff, value_in;
   logic [7:0]      serr_ff, serr_in;

   logic [8:0]      total_raw;
   logic [7:0]      pos_next;
   logic [7:0]      sum_next;
   logic            rx_done;
   logic            tick_expire;
   logic            outcome;
   logic [1:0]      outcome_status;
   logic [15:0]     outcome_value;
   logic [7:0]      outcome_err;

   assign req_ready = (cnt_ff == 4'd0) || (cnt_ff == 4'd1 && rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (cnt_ff != 4'd0);
   assign rsp_fire  = rsp_valid && rsp_ready;

   sbrt_pkt_build u_pkt_build (
      .req (req_data),
      .pkt (pkt)
   );

   assign total_raw   = {1'b0, req_data.read_len} + STATUS_EXTRA;
   assign pos_next    = pos_ff + 8'd1;
   assign sum_next    = (pos_ff >= 8'd2) ? sum_ff + req_data.rx_byte : sum_ff;
   assign rx_done     = (phase_ff == PH_COLLECT) && (pos_next >= total_ff);
   assign tick_expire = (phase_ff != PH_IDLE) && (ticks_ff <= 16'd1);

   // phase next state
   always_comb begin
      phase_in = phase_ff;
      if (req_fire) begin
         unique case (req_data.cmd) inside
            CMD_READ: begin
               phase_in = PH_HUNT;
            end
            CMD_WRITE_BYTE, CMD_WRITE_WORD: begin
               phase_in = PH_IDLE;
            end
            CMD_RX_BYTE: begin
               if (phase_ff == PH_HUNT && req_data.rx_byte == SYNC_BYTE) begin
                  phase_in = PH_COLLECT;
               end else if (rx_done) begin
                  phase_in = PH_IDLE;
               end
            end
            CMD_TICK: begin
               if (tick_expire) begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // receive datapath and outcome
   always_comb begin
      pos_in         = pos_ff;
      total_in       = total_ff;
      sum_in         = sum_ff;
      ticks_in       = ticks_ff;
      count_in       = count_ff;
      err_in         = err_ff;
      vlo_in         = vlo_ff;
      vhi_in         = vhi_ff;
      outcome        = 1'b0;
      outcome_status = STATUS_OK;
      outcome_value  = '0;
      outcome_err    = '0;
      if (req_fire) begin
         case (req_data.cmd)
            CMD_READ: begin
               pos_in   = '0;
               sum_in   = '0;
               err_in   = '0;
               vlo_in   = '0;
               vhi_in   = '0;
               count_in = req_data.read_len;
               total_in = (total_raw > TOTAL_MAX) ? TOTAL_MAX[7:0] : total_raw[7:0];
               ticks_in = timeout_ff;
            end
            CMD_RX_BYTE: begin
               if (phase_ff == PH_HUNT) begin
                  ticks_in = timeout_ff;
                  if (req_data.rx_byte == SYNC_BYTE) begin
                     pos_in = 8'd1;
                     sum_in = '0;
                  end
               end else if (phase_ff == PH_COLLECT) begin
                  ticks_in = timeout_ff;
                  sum_in   = sum_next;
                  pos_in   = pos_next;
                  if (pos_ff == 8'd4) begin
                     err_in = req_data.rx_byte;
                  end else if (pos_ff == 8'd5) begin
                     vlo_in = req_data.rx_byte;
                  end else if (pos_ff == 8'd6) begin
                     vhi_in = req_data.rx_byte;
                  end
                  if (rx_done) begin
                     outcome = 1'b1;
                     if (sum_next == CHECKSUM_GOOD) begin
                        outcome_status = STATUS_OK;
                        outcome_err    = err_in;
                        outcome_value  = (count_ff != 8'd1) ? {vhi_in, vlo_in}
                                                            : {8'h00, vlo_in};
                     end else begin
                        outcome_status = STATUS_CHECKSUM;
                     end
                  end
               end
            end
            CMD_TICK: begin
               if (tick_expire) begin
                  ticks_in       = '0;
                  outcome        = 1'b1;
                  outcome_status = STATUS_TIMEOUT;
               end else if (phase_ff != PH_IDLE) begin
                  ticks_in = ticks_ff - 16'd1;
               end
            end
            default: begin
               outcome = 1'b0;
            end
         endcase
      end
   end

   // result register: load a packet or an outcome, else advance on each beat
   always_comb begin
      bytes_in  = bytes_ff;
      cnt_in    = cnt_ff;
      kind_in   = kind_ff;
      status_in = status_ff;
      value_in  = value_ff;
      serr_in   = serr_ff;
      if (rsp_fire) begin
         bytes_in = {8'h00, bytes_ff[8:1]};
         cnt_in   = cnt_ff - 4'd1;
      end
      if (req_fire && pkt.len != 4'd0) begin
         bytes_in  = pkt.bytes;
         cnt_in    = pkt.len;
         kind_in   = KIND_BYTE;
         status_in = STATUS_OK;
         value_in  = '0;
         serr_in   = '0;
      end else if (outcome) begin
         cnt_in    = 4'd1;
         kind_in   = KIND_OUTCOME;
         status_in = outcome_status;
         value_in  = outcome_value;
         serr_in   = outcome_err;
      end
   end

   always_comb begin
      rsp_data.out_kind    = kind_ff;
      rsp_data.tx_byte     = (kind_ff == KIND_BYTE) ? bytes_ff[0] : 8'h00;
      rsp_data.last        = (kind_ff == KIND_BYTE) && (cnt_ff == 4'd1);
      rsp_data.status      = status_ff;
      rsp_data.read_value  = value_ff;
      rsp_data.servo_error = serr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         phase_ff   <= PH_IDLE;
         pos_ff     <= '0;
         total_ff   <= '0;
         sum_ff     <= '0;
         ticks_ff   <= '0;
         count_ff   <= '0;
         err_ff     <= '0;
         vlo_ff     <= '0;
         vhi_ff     <= '0;
         cnt_ff     <= '0;
         kind_ff    <= KIND_BYTE;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         total_ff <= total_in;
         sum_ff   <= sum_in;
         ticks_ff <= ticks_in;
         count_ff <= count_in;
         err_ff   <= err_in;
         vlo_ff   <= vlo_in;
         vhi_ff   <= vhi_in;
         cnt_ff   <= cnt_in;
         kind_ff  <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff  <= bytes_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      serr_ff   <= serr_in;
   end

   `ASSERT_NEXT(a_read_starts_hunt, clock, reset, req_fire && req_data.cmd == CMD_READ, phase_ff == PH_HUNT && cnt_ff == PKT_LEN_SHORT, "read request did not start hunt with full packet")
   `ASSERT_CLK(a_outcome_single, clock, reset, !(rsp_valid && rsp_data.out_kind) || cnt_ff == 4'd1, "outcome beat not alone in result register")
   `ASSERT_NEXT(a_timeout_idles, clock, reset, req_fire && req_data.cmd == CMD_TICK && tick_expire, phase_ff == PH_IDLE && rsp_valid && rsp_data.status == STATUS_TIMEOUT, "expired tick did not report timeout")

endmodule

// ===== rtl/sbrt_pkt_build.sv =====
// ----------------------------------------------------------------------------
// sbrt_pkt_build
// Instruction packet assembly with inverted-sum checksum.
// ----------------------------------------------------------------------------
module sbrt_pkt_build (
   input  sbrt_pkg::sbrt_req_type req,
   output sbrt_pkg::sbrt_pkt_type pkt
);
   import sbrt_pkg::*;

   logic [7:0] lo;
   logic [7:0] hi;
   logic [7:0] sum_read;
   logic [7:0] sum_byte;
   logic [7:0] sum_word;

   assign lo       = req.write_data[7:0];
   assign hi       = req.write_data[15:8];
   assign sum_read = req.servo_id + LEN_SHORT + INSTR_READ + req.reg_addr + req.read_len;
   assign sum_byte = req.servo_id + LEN_SHORT + INSTR_WRITE + req.reg_addr + lo;
   assign sum_word = req.servo_id + LEN_WORD + INSTR_WRITE + req.reg_addr + lo + hi;

   always_comb begin
      pkt.bytes    = '0;
      pkt.len      = '0;
      pkt.bytes[0] = SYNC_BYTE;
      pkt.bytes[1] = SYNC_BYTE;
      pkt.bytes[2] = req.servo_id;
      pkt.bytes[5] = req.reg_addr;
      unique case (req.cmd)
         CMD_READ: begin
            pkt.bytes[3] = LEN_SHORT;
            pkt.bytes[4] = INSTR_READ;
            pkt.bytes[6] = req.read_len;
            pkt.bytes[7] = ~sum_read;
            pkt.len      = PKT_LEN_SHORT;
         end
         CMD_WRITE_BYTE: begin
            pkt.bytes[3] = LEN_SHORT;
            pkt.bytes[4] = INSTR_WRITE;
            pkt.bytes[6] = lo;
            pkt.bytes[7] = ~sum_byte;
            pkt.len      = PKT_LEN_SHORT;
         end
         CMD_WRITE_WORD: begin
            pkt.bytes[3] = LEN_WORD;
            pkt.bytes[4] = INSTR_WRITE;
            pkt.bytes[6] = lo;
            pkt.bytes[7] = hi;
            pkt.bytes[8] = ~sum_word;
            pkt.len      = PKT_LEN_WORD;
         end
         default: begin
            pkt.len = '0;
         end
      endcase
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo bus register transaction unit testbench
// Drives read and write requests, received status bytes and ticks into the
// unit, tracks the bus master state in a scoreboard class, and checks every
// transmit byte beat and read outcome beat in order. Runs directed cases and
// then random transactions under several timeout settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
   import sbrt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   class bus_transaction_tracker;
      sbrt_rsp_type expected_beats[$];
      int           failures;
      int           active_items;
      logic [15:0]  timeout_reg;
      phase_type    bus_phase;
      logic [7:0]   rx_position;
      logic [7:0]   frame_total;
      logic [7:0]   frame_sum;
      logic [7:0]   wanted_len;
      logic [7:0]   status_error;
      logic [7:0]   data_low;
      logic [7:0]   data_high;
      logic [15:0]  ticks_left;

      function new();
         failures     = 0;
         active_items = 0;
         timeout_reg  = TIMEOUT_RESET;
         bus_phase    = PH_IDLE;
         rx_position  = '0;
         frame_total  = '0;
         frame_sum    = '0;
         wanted_len   = '0;
         status_error = '0;
         data_low     = '0;
         data_high    = '0;
         ticks_left   = '0;
      endfunction

      function void load_timeout(logic [15:0] value);
         timeout_reg = value;
      endfunction

      function void push_beat(logic kind, logic [7:0] tx, logic fin, logic [1:0] st,
                              logic [15:0] value, logic [7:0] err);
         sbrt_rsp_type beat;
         beat.out_kind    = kind;
         beat.tx_byte     = tx;
         beat.last        = fin;
         beat.status      = st;
         beat.read_value  = value;
         beat.servo_error = err;
         expected_beats.push_back(beat);
      endfunction

      function void accept_request(sbrt_req_type item);
         logic [7:0]  body [9];
         logic [7:0]  lo;
         logic [7:0]  hi;
         logic [8:0]  span;
         logic [15:0] value;
         int          n;
         n  = 0;
         lo = item.write_data[7:0];
         hi = item.write_data[15:8];
         body[0] = SYNC_BYTE;
         body[1] = SYNC_BYTE;
         body[2] = item.servo_id;
         body[5] = item.reg_addr;
         case (item.cmd)
            CMD_READ: begin
               body[3] = LEN_SHORT;
               body[4] = INSTR_READ;
               body[6] = item.read_len;
               body[7] = ~(item.servo_id + LEN_SHORT + INSTR_READ + item.reg_addr
                           + item.read_len);
               n = PKT_LEN_SHORT;
               span = {1'b0, item.read_len} + STATUS_EXTRA;
               bus_phase    = PH_HUNT;
               wanted_len   = item.read_len;
               frame_total  = (span > TOTAL_MAX) ? TOTAL_MAX[7:0] : span[7:0];
               rx_position  = '0;
               frame_sum    = '0;
               status_error = '0;
               data_low     = '0;
               data_high    = '0;
               ticks_left   = timeout_reg;
            end
            CMD_WRITE_BYTE: begin
               body[3] = LEN_SHORT;
               body[4] = INSTR_WRITE;
               body[6] = lo;
               body[7] = ~(item.servo_id + LEN_SHORT + INSTR_WRITE + item.reg_addr + lo);
               n = PKT_LEN_SHORT;
               bus_phase = PH_IDLE;
            end
            CMD_WRITE_WORD: begin
               body[3] = LEN_WORD;
               body[4] = INSTR_WRITE;
               body[6] = lo;
               body[7] = hi;
               body[8] = ~(item.servo_id + LEN_WORD + INSTR_WRITE + item.reg_addr + lo + hi);
               n = PKT_LEN_WORD;
               bus_phase = PH_IDLE;
            end
            CMD_RX_BYTE: begin
               if (bus_phase != PH_IDLE) begin
                  active_items++;
                  ticks_left = timeout_reg;
                  if (bus_phase == PH_HUNT) begin
                     if (item.rx_byte == SYNC_BYTE) begin
                        bus_phase   = PH_COLLECT;
                        rx_position = 8'd1;
                        frame_sum   = '0;
                     end
                  end else begin
                     if (rx_position >= 8'd2) frame_sum = frame_sum + item.rx_byte;
                     if (rx_position == 8'd4) status_error = item.rx_byte;
                     else if (rx_position == 8'd5) data_low = item.rx_byte;
                     else if (rx_position == 8'd6) data_high = item.rx_byte;
                     rx_position = rx_position + 8'd1;
                     if (rx_position >= frame_total) begin
                        bus_phase = PH_IDLE;
                        if (frame_sum == CHECKSUM_GOOD) begin
                           value = {8'h00, data_low};
                           if (wanted_len != 8'd1) value[15:8] = data_high;
                           push_beat(KIND_OUTCOME, 8'h00, 1'b0, STATUS_OK, value, status_error);
                        end else begin
                           push_beat(KIND_OUTCOME, 8'h00, 1'b0, STATUS_CHECKSUM, 16'h0000, 8'h00);
                        end
                     end
                  end
               end
            end
            CMD_TICK: begin
               if (bus_phase != PH_IDLE) begin
                  active_items++;
                  if (ticks_left <= 16'd1) begin
                     ticks_left = '0;
                     bus_phase  = PH_IDLE;
                     push_beat(KIND_OUTCOME, 8'h00, 1'b0, STATUS_TIMEOUT, 16'h0000, 8'h00);
                  end else begin
                     ticks_left = ticks_left - 16'd1;
                  end
               end
            end
            default: ;
         endcase
         if (n > 0) active_items++;
         for (int k = 0; k < n; k++)
            push_beat(KIND_BYTE, body[k], k == n - 1, STATUS_OK, 16'h0000, 8'h00);
      endfunction

      function void report_field(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            failures++;
            if (failures <= 100)
               $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         end
      endfunction

      function void match_beat(sbrt_rsp_type got);
         sbrt_rsp_type want;
         if (expected_beats.size() == 0) begin
            failures++;
            if (failures <= 100)
               $display("%0t: result beat expected none actual %h", $time, got);
            return;
         end
         want = expected_beats.pop_front();
         report_field("out_kind", want.out_kind, got.out_kind);
         report_field("tx_byte", want.tx_byte, got.tx_byte);
         report_field("last", want.last, got.last);
         report_field("status", want.status, got.status);
         report_field("read_value", want.read_value, got.read_value);
         report_field("servo_error", want.servo_error, got.servo_error);
      endfunction
   endclass

   logic         clock;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_ready;
   sbrt_req_type req_data    = '0;
   logic         rsp_valid;
   logic         rsp_ready   = 1'b0;
   sbrt_rsp_type rsp_data;
   logic         csr_wr_en   = 1'b0;
   logic [15:0]  csr_wr_data = '0;

   int          send_idle_pct   = 0;
   int          ready_stall_pct = 0;
   int          cycle_count     = 0;
   int unsigned cur_timeout     = TIMEOUT_RESET;

   bus_transaction_tracker tracker = new();

   servo_bus_register_transaction_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= ready_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) tracker.load_timeout(csr_wr_data);
         if (req_valid && req_ready) tracker.accept_request(req_data);
         if (rsp_valid && rsp_ready) tracker.match_beat(rsp_data);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic sbrt_req_type random_item(logic [2:0] cmd);
      logic [63:0]  bits;
      sbrt_req_type item;
      bits = {$urandom, $urandom};
      item = bits[$bits(sbrt_req_type)-1:0];
      item.cmd = cmd;
      return item;
   endfunction

   function automatic int unsigned effective_timeout();
      return (cur_timeout == 0) ? 1 : cur_timeout;
   endfunction

   function automatic logic [7:0] pick_len();
      int r;
      r = $urandom_range(99);
      if (r < 5) return 8'd0;
      if (r < 7) return 8'($urandom_range(249, 255));
      if (r < 17) return 8'($urandom_range(5, 30));
      return 8'($urandom_range(1, 4));
   endfunction

   task automatic send_beat(input sbrt_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_request(input logic [2:0] cmd, input logic [7:0] id,
                               input logic [7:0] addr, input logic [7:0] len,
                               input logic [15:0] data);
      sbrt_req_type item;
      item = random_item(cmd);
      item.servo_id   = id;
      item.reg_addr   = addr;
      item.read_len   = len;
      item.write_data = data;
      send_beat(item);
   endtask

   task automatic send_rx(input logic [7:0] value);
      sbrt_req_type item;
      item = random_item(CMD_RX_BYTE);
      item.rx_byte = value;
      send_beat(item);
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_beat(random_item(CMD_TICK));
   endtask

   task automatic send_status_packet(input logic [7:0] len, input int cut);
      logic [7:0] frame [256];
      logic [8:0] span;
      logic [7:0] sum;
      int         n;
      int         room;
      span = {1'b0, len} + STATUS_EXTRA;
      n = (span > TOTAL_MAX) ? TOTAL_MAX : span;
      room = (effective_timeout() > 4) ? 3 : effective_timeout() - 1;
      frame[0] = SYNC_BYTE;
      frame[1] = ($urandom_range(19) == 0) ? 8'($urandom) : SYNC_BYTE;
      frame[2] = 8'($urandom);
      frame[3] = len + 8'd2;
      frame[4] = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom);
      sum = frame[2] + frame[3] + frame[4];
      for (int k = 5; k < n - 1; k++) begin
         frame[k] = 8'($urandom);
         sum = sum + frame[k];
      end
      frame[n-1] = ~sum;
      if ($urandom_range(6) == 0) frame[n-1] = frame[n-1] ^ 8'($urandom_range(1, 255));
      if (cut > n) cut = n;
      for (int k = 0; k < cut; k++) begin
         if ($urandom_range(3) == 0) send_ticks($urandom_range(0, room));
         send_rx(frame[k]);
      end
   endtask

   // style: 0 whole reply, 1 cut short then run out the timer if it is at most 64, 2 cut short only
   task automatic read_transaction(input int style);
      sbrt_req_type item;
      item = random_item(CMD_READ);
      item.read_len = pick_len();
      send_beat(item);
      repeat ($urandom_range(0, 2)) send_rx(8'($urandom_range(0, 254)));
      send_status_packet(item.read_len, (style == 0) ? 256 : $urandom_range(0, 8));
      if (style == 1 && effective_timeout() <= 64) send_ticks(effective_timeout());
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_beats.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_timeout(input int unsigned value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= 16'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_timeout = value;
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
         1: begin send_idle_pct = 58; ready_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  ready_stall_pct = 58; end
         default: begin send_idle_pct = 31; ready_stall_pct = 31; end
      endcase
   endtask

   task automatic directed_items();
      logic [7:0] short_frame [6];
      logic [7:0] bad_frame [8];
      short_frame = '{SYNC_BYTE, SYNC_BYTE, 8'hFE, 8'h02, 8'h40, 8'hBF};
      bad_frame   = '{8'h00, SYNC_BYTE, SYNC_BYTE, 8'h01, 8'h03, 8'h00, 8'h5A, 8'h00};
      send_rx(SYNC_BYTE);
      send_ticks(1);
      send_beat(random_item(3'd5));
      send_beat(random_item(3'd7));
      send_request(CMD_WRITE_BYTE, 8'h00, 8'h00, 8'h00, 16'hFF00);
      send_request(CMD_WRITE_WORD, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
      send_request(CMD_READ, 8'hFE, 8'h24, 8'h00, 16'h0000);
      foreach (short_frame[k]) send_rx(short_frame[k]);
      send_request(CMD_READ, 8'h01, 8'h00, 8'hFF, 16'h0000);
      send_request(CMD_READ, 8'h01, 8'h2B, 8'h01, 16'h0000);
      foreach (bad_frame[k]) send_rx(bad_frame[k]);
      send_request(CMD_READ, 8'h10, 8'h00, 8'h02, 16'hFFFF);
   endtask

   task automatic random_phase(input int target);
      int start;
      int pick;
      start = tracker.active_items;
      while (tracker.active_items - start < target) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            read_transaction(0);
         end else if (pick < 62) begin
            send_beat(random_item(($urandom_range(1) == 0) ? CMD_WRITE_BYTE : CMD_WRITE_WORD));
         end else if (pick < 74) begin
            read_transaction(1);
         end else if (pick < 84) begin
            read_transaction(2);
         end else begin
            repeat ($urandom_range(1, 3)) send_beat(random_item(3'($urandom_range(3, 7))));
         end
      end
   endtask

   initial begin
      int unsigned timeouts [6];
      timeouts = '{5, 1, 0, 65535, $urandom_range(2, 30), $urandom_range(1, 65535)};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_items();
      for (int p = 0; p < 6; p++) begin
         write_timeout(timeouts[p]);
         set_idling(p % 4);
         random_phase(55);
      end
      drain();
      if (tracker.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/sbrt_pkg.sv
rtl/sbrt_pkt_build.sv
rtl/servo_bus_register_transaction_unit.sv
verif/testbench.sv
